[rtl/drct_pkg.sv]
// Shared constants, codes and types of the DMA region check table.
`timescale 1ns / 1ps
`default_nettype none
package drct_pkg;

   localparam int MAX_REGIONS    = 16;
   localparam int DMA_SPACE_BITS = 40;
   localparam int IDX_W          = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

   localparam int ACTION_W = 2;
   localparam int ADDR_W   = 52;
   localparam int LEN_W    = 41;
   localparam int STATUS_W = 3;
   localparam int APB_W    = 41;
   localparam int SYSB_W   = 40;
   localparam int LIMIT_W  = 41;

   // wide sums never wrap
   localparam int SUM_W = ADDR_W + 1;
   localparam int END_W = ((DMA_SPACE_BITS > LEN_W) ? DMA_SPACE_BITS : LEN_W) + 1;

   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_IDX_LSB = 3;
   localparam int CSR_IDX_W   = CSR_ADDR_W - CSR_IDX_LSB;

   localparam logic [CSR_IDX_W-1:0] CSR_CARD_SIDE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_APERT_BASE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_APERT_BYTES  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYSMEM_BASE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SYSMEM_LIMIT = 3'd4;

   localparam logic [SYSB_W-1:0]  SYSMEM_BASE_RST  = SYSB_W'(1) << 39;
   localparam logic [LIMIT_W-1:0] SYSMEM_LIMIT_RST = LIMIT_W'(1) << 39;

   localparam logic [ACTION_W-1:0] ACT_REGISTER   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DEREGISTER = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_VERIFY     = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_UNKNOWN    = 2'd3;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_RANGE   = 3'd1,
      ST_OVERLAP = 3'd2,
      ST_NOREG   = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_XLATE,
      CTL_SCAN,
      CTL_DONE
   } ctl_state_type;

   typedef struct packed {
      logic                card_side;
      logic [ADDR_W-1:0]   ap_base;
      logic [APB_W-1:0]    ap_bytes;
      logic [SYSB_W-1:0]   sys_base;
      logic [LIMIT_W-1:0]  sys_limit;
   } cfg_type;

   typedef struct packed {
      logic                valid;
      logic [ACTION_W-1:0] action;
      logic [ADDR_W-1:0]   addr;
      logic [LEN_W-1:0]    len;
   } req_type;

   typedef struct packed {
      logic                      valid;
      logic                      bad;
      logic [ACTION_W-1:0]       action;
      logic [DMA_SPACE_BITS-1:0] t;
      logic [END_W-1:0]          tend;
      logic                      host;
   } xl_type;

   typedef struct packed {
      logic [DMA_SPACE_BITS-1:0] t;
      logic [END_W-1:0]          tend;
   } qry_type;

   typedef struct packed {
      logic             valid;
      logic             overlap;
      logic             free_found;
      logic [IDX_W-1:0] free_idx;
      logic             cont_found;
      logic [IDX_W-1:0] cont_idx;
   } tok_type;

   typedef struct packed {
      logic                      en;
      logic                      set;
      logic [IDX_W-1:0]          idx;
      logic [DMA_SPACE_BITS-1:0] base;
      logic [END_W-1:0]          send;
   } slot_wr_type;

endpackage
`default_nettype wire

[rtl/drct_xlate.sv]
// Three-stage translation of a request address into DMA space.
`timescale 1ns / 1ps
`default_nettype none
module drct_xlate (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire drct_pkg::cfg_type cfg,
   input  wire drct_pkg::req_type req_in,
   output drct_pkg::xl_type      x_out
);
   import drct_pkg::*;

   localparam logic [SUM_W-1:0] LIM = SUM_W'(1) << DMA_SPACE_BITS;

   // stage 1
   logic                s1_valid_ff;
   logic                s1_bad_ff, s1_bad_in;
   logic [ACTION_W-1:0] s1_action_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic [LEN_W-1:0]    s1_len_ff;
   logic [SUM_W-1:0]    s1_end_ff, s1_end_in;
   logic [SUM_W-1:0]    s1_hi_ff, s1_hi_in;
   logic                s1_ap_ge_ff, s1_ap_ge_in;
   logic [ADDR_W-1:0]   s1_ap_off_ff, s1_ap_off_in;
   logic [SUM_W-1:0]    s1_sys_t_ff, s1_sys_t_in;
   logic [SUM_W-1:0]    ap_diff;

   // stage 2
   logic                      s2_valid_ff;
   logic                      s2_bad_ff, s2_bad_in;
   logic [ACTION_W-1:0]       s2_action_ff;
   logic [DMA_SPACE_BITS-1:0] s2_t_ff, s2_t_in;
   logic [LEN_W-1:0]          s2_len_ff;
   logic [SUM_W-1:0]          sel_t;
   logic                      in_ap, miss;

   // stage 3
   logic                      s3_valid_ff;
   logic                      s3_bad_ff;
   logic [ACTION_W-1:0]       s3_action_ff;
   logic [DMA_SPACE_BITS-1:0] s3_t_ff;
   logic [END_W-1:0]          s3_tend_ff, s3_tend_in;
   logic                      s3_host_ff, s3_host_in;

   always_comb begin
      s1_bad_in    = (req_in.action == ACT_UNKNOWN) || (req_in.len == '0);
      s1_end_in    = SUM_W'(req_in.addr) + SUM_W'(req_in.len);
      s1_hi_in     = SUM_W'(cfg.ap_base) + SUM_W'(cfg.ap_bytes);
      ap_diff      = SUM_W'(req_in.addr) - SUM_W'(cfg.ap_base);
      s1_ap_ge_in  = ~ap_diff[SUM_W-1];
      s1_ap_off_in = ap_diff[ADDR_W-1:0];
      s1_sys_t_in  = SUM_W'(req_in.addr) + SUM_W'(cfg.sys_base);
   end

   always_comb begin
      in_ap = s1_ap_ge_ff && (s1_end_ff <= s1_hi_ff);
      if (cfg.card_side) begin
         sel_t = SUM_W'(s1_addr_ff);
         miss  = s1_end_ff > LIM;
      end else if (in_ap) begin
         sel_t = SUM_W'(s1_ap_off_ff);
         miss  = 1'b0;
      end else begin
         sel_t = s1_sys_t_ff;
         miss  = !(s1_end_ff < SUM_W'(cfg.sys_limit));
      end
      // a translated address of zero counts as out of range
      s2_bad_in = s1_bad_ff || miss || (sel_t >= LIM) ||
                  (sel_t[DMA_SPACE_BITS-1:0] == '0);
      s2_t_in   = sel_t[DMA_SPACE_BITS-1:0];
   end

   always_comb begin
      s3_host_in = SUM_W'(s2_t_ff) > SUM_W'(cfg.sys_base);
      s3_tend_in = END_W'(s2_t_ff) + END_W'(s2_len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_in.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_in.valid) begin
         s1_bad_ff    <= s1_bad_in;
         s1_action_ff <= req_in.action;
         s1_addr_ff   <= req_in.addr;
         s1_len_ff    <= req_in.len;
         s1_end_ff    <= s1_end_in;
         s1_hi_ff     <= s1_hi_in;
         s1_ap_ge_ff  <= s1_ap_ge_in;
         s1_ap_off_ff <= s1_ap_off_in;
         s1_sys_t_ff  <= s1_sys_t_in;
      end
      if (s1_valid_ff) begin
         s2_bad_ff    <= s2_bad_in;
         s2_action_ff <= s1_action_ff;
         s2_t_ff      <= s2_t_in;
         s2_len_ff    <= s1_len_ff;
      end
      if (s2_valid_ff) begin
         s3_bad_ff    <= s2_bad_ff;
         s3_action_ff <= s2_action_ff;
         s3_t_ff      <= s2_t_ff;
         s3_tend_ff   <= s3_tend_in;
         s3_host_ff   <= s3_host_in;
      end
   end

   always_comb begin
      x_out.valid  = s3_valid_ff;
      x_out.bad    = s3_bad_ff;
      x_out.action = s3_action_ff;
      x_out.t      = s3_t_ff;
      x_out.tend   = s3_tend_ff;
      x_out.host   = s3_host_ff;
   end

endmodule
`default_nettype wire

[rtl/drct_cell.sv]
// One region slot: holds a stored region and folds its checks into the passing token.
`timescale 1ns / 1ps
`default_nettype none
module drct_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [drct_pkg::IDX_W-1:0] cell_idx,
   input  wire drct_pkg::qry_type       qry,
   input  wire drct_pkg::tok_type       tok_prev,
   output drct_pkg::tok_type            tok_next,
   input  wire drct_pkg::slot_wr_type   wr
);
   import drct_pkg::*;

   logic                      valid_ff, valid_in;
   logic [DMA_SPACE_BITS-1:0] base_ff;
   logic [END_W-1:0]          send_ff;
   tok_type                   tok_ff, tok_in;
   logic                      ovl, cont, sel;

   always_comb begin
      ovl  = valid_ff && (END_W'(qry.t) < send_ff) && (END_W'(base_ff) < qry.tend);
      cont = valid_ff && (base_ff <= qry.t) && (send_ff >= qry.tend);

      tok_in            = tok_prev;
      tok_in.overlap    = tok_prev.overlap | ovl;
      // lowest free slot and lowest containing slot win
      tok_in.free_found = tok_prev.free_found | ~valid_ff;
      tok_in.free_idx   = tok_prev.free_found ? tok_prev.free_idx : cell_idx;
      tok_in.cont_found = tok_prev.cont_found | cont;
      tok_in.cont_idx   = tok_prev.cont_found ? tok_prev.cont_idx : cell_idx;

      sel      = wr.en && (wr.idx == cell_idx);
      valid_in = sel ? wr.set : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sel && wr.set) begin
         base_ff <= wr.base;
         send_ff <= wr.send;
      end
   end

   assign tok_next = tok_ff;

endmodule
`default_nettype wire

[rtl/dma_region_check_table_unit.sv]
// Top level of the DMA region check table: control, registers and the slot row.
//
// Requests (req_action, req_phys_addr, req_length) arrive on a valid/ready
// channel; each transaction gives exactly one response (rsp_status,
// rsp_bus_addr, rsp_mem_type) on a valid/ready channel. Configuration
// registers are written through the APB-style csr port, 8 bytes per register;
// the user must write them while the block is idle; it does not enforce this.
// A request is translated in three register stages, then a token walks the
// row of MAX_REGIONS slot cells, one cell per cycle, gathering overlap,
// first free slot and first containing slot. The table update happens when
// the response is loaded.
// Only one request is in flight: a new one is taken only once the previous
// one has walked the whole row and its response has been loaded.
// A request can be taken while the previous response still waits; if the
// receiver stalls, the finished result waits in its final step and the
// response register holds its value until rsp_ready.
// Reset empties the table and loads the register defaults; req_ready is
// low while reset is high.
`timescale 1ns / 1ps
`default_nettype none
module dma_region_check_table_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [drct_pkg::ACTION_W-1:0]       req_action,
   input  wire logic [drct_pkg::ADDR_W-1:0]         req_phys_addr,
   input  wire logic [drct_pkg::LEN_W-1:0]          req_length,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [drct_pkg::STATUS_W-1:0]            rsp_status,
   output logic [drct_pkg::DMA_SPACE_BITS-1:0]      rsp_bus_addr,
   output logic                                     rsp_mem_type,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [drct_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [drct_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [drct_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                     pready
);
   import drct_pkg::*;

   cfg_type                  cfg_ff;
   logic [CSR_IDX_W-1:0]     csr_idx;
   logic                     csr_wr;

   ctl_state_type            state_ff, state_in;
   logic                     req_ready_c, launch, fin_load, done_fire;
   tok_type                  fin_ff;
   tok_type                  chain [MAX_REGIONS+1];
   req_type                  req_in;
   xl_type                   x_out;
   qry_type                  qry;
   slot_wr_type              wr;
   status_type               status;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff;
   logic [DMA_SPACE_BITS-1:0] rsp_bus_addr_ff;
   logic                      rsp_mem_type_ff;

   // configuration registers
   assign csr_idx = paddr[CSR_ADDR_W-1:CSR_IDX_LSB];
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.card_side <= 1'b0;
         cfg_ff.ap_base   <= '0;
         cfg_ff.ap_bytes  <= '0;
         cfg_ff.sys_base  <= SYSMEM_BASE_RST;
         cfg_ff.sys_limit <= SYSMEM_LIMIT_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_CARD_SIDE:    cfg_ff.card_side <= pwdata[0];
            CSR_APERT_BASE:   cfg_ff.ap_base   <= pwdata[ADDR_W-1:0];
            CSR_APERT_BYTES:  cfg_ff.ap_bytes  <= pwdata[APB_W-1:0];
            CSR_SYSMEM_BASE:  cfg_ff.sys_base  <= pwdata[SYSB_W-1:0];
            CSR_SYSMEM_LIMIT: cfg_ff.sys_limit <= pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_CARD_SIDE:    prdata = CSR_DATA_W'(cfg_ff.card_side);
         CSR_APERT_BASE:   prdata = CSR_DATA_W'(cfg_ff.ap_base);
         CSR_APERT_BYTES:  prdata = CSR_DATA_W'(cfg_ff.ap_bytes);
         CSR_SYSMEM_BASE:  prdata = CSR_DATA_W'(cfg_ff.sys_base);
         CSR_SYSMEM_LIMIT: prdata = CSR_DATA_W'(cfg_ff.sys_limit);
         default:          prdata = '0;
      endcase
   end

   // control
   always_comb begin
      state_in    = state_ff;
      req_ready_c = 1'b0;
      launch      = 1'b0;
      fin_load    = 1'b0;
      done_fire   = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            req_ready_c = !reset;
            if (req_valid) state_in = CTL_XLATE;
         end
         CTL_XLATE: begin
            if (x_out.valid) begin
               launch   = 1'b1;
               state_in = CTL_SCAN;
            end
         end
         CTL_SCAN: begin
            if (chain[MAX_REGIONS].valid) begin
               fin_load = 1'b1;
               state_in = CTL_DONE;
            end
         end
         CTL_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               done_fire = 1'b1;
               state_in  = CTL_IDLE;
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_c;

   always_comb begin
      req_in.valid  = req_valid && req_ready_c;
      req_in.action = req_action;
      req_in.addr   = req_phys_addr;
      req_in.len    = req_length;
   end

   drct_xlate u_xlate (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req_in (req_in),
      .x_out  (x_out)
   );

   // slot row
   always_comb begin
      qry.t    = x_out.t;
      qry.tend = x_out.tend;

      chain[0]            = '0;
      chain[0].valid      = launch;
   end

   for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
      drct_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(g)),
         .qry      (qry),
         .tok_prev (chain[g]),
         .tok_next (chain[g+1]),
         .wr       (wr)
      );
   end

   always_ff @(posedge clock) begin
      if (fin_load) fin_ff <= chain[MAX_REGIONS];
   end

   // decision and table update
   always_comb begin
      priority if (x_out.bad) begin
         status = ST_RANGE;
      end else if (x_out.action == ACT_REGISTER) begin
         priority if (fin_ff.overlap) status = ST_OVERLAP;
         else if (!fin_ff.free_found) status = ST_FULL;
         else                         status = ST_OK;
      end else if (!fin_ff.cont_found) begin
         status = ST_NOREG;
      end else begin
         status = ST_OK;
      end

      wr.en   = done_fire && (status == ST_OK) &&
                ((x_out.action == ACT_REGISTER) || (x_out.action == ACT_DEREGISTER));
      wr.set  = x_out.action == ACT_REGISTER;
      wr.idx  = (x_out.action == ACT_REGISTER) ? fin_ff.free_idx : fin_ff.cont_idx;
      wr.base = x_out.t;
      wr.send = x_out.tend;

      rsp_valid_in = done_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_status_ff   <= status;
         rsp_bus_addr_ff <= (status == ST_OK) ? x_out.t : '0;
         rsp_mem_type_ff <= (status == ST_OK) && x_out.host;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_bus_addr = rsp_bus_addr_ff;
   assign rsp_mem_type = rsp_mem_type_ff;

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for the DMA region check table: directed and random requests.
`timescale 1ns / 1ps
module tb_top;
   import drct_pkg::*;

   // Shadow copy of the region table and configuration; predicts each response.
   class region_table_shadow;
      typedef struct {
         status_type                status;
         logic [DMA_SPACE_BITS-1:0] bus_addr;
         logic                      mem_type;
      } reply_type;

      bit          card_side;
      logic [63:0] ap_base, ap_bytes, sys_base, sys_limit;
      bit          slot_valid[MAX_REGIONS];
      logic [63:0] slot_base[MAX_REGIONS];
      logic [63:0] slot_size[MAX_REGIONS];
      logic [63:0] slot_phys[MAX_REGIONS];
      reply_type   expected_replies[$];
      int          errors;
      int          compared;
      int          tally[5];

      function new();
         card_side = 1'b0;
         ap_base   = 64'd0;
         ap_bytes  = 64'd0;
         sys_base  = 64'(SYSMEM_BASE_RST);
         sys_limit = 64'(SYSMEM_LIMIT_RST);
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         errors   = 0;
         compared = 0;
         foreach (tally[i]) tally[i] = 0;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      function void set_csr(logic [CSR_IDX_W-1:0] idx, logic [63:0] value);
         case (idx)
            CSR_CARD_SIDE:    card_side = value[0];
            CSR_APERT_BASE:   ap_base   = value & ((64'd1 << ADDR_W) - 1);
            CSR_APERT_BYTES:  ap_bytes  = value & ((64'd1 << APB_W) - 1);
            CSR_SYSMEM_BASE:  sys_base  = value & ((64'd1 << SYSB_W) - 1);
            CSR_SYSMEM_LIMIT: sys_limit = value & ((64'd1 << LIMIT_W) - 1);
            default: ;
         endcase
      endfunction

      // physical range to DMA space; 0 means out of range
      function logic [63:0] to_dma(logic [63:0] a, logic [63:0] l);
         logic [63:0] lim, stop, t;
         lim  = 64'd1 << DMA_SPACE_BITS;
         stop = a + l;
         if (card_side) begin
            if (stop > lim) return 64'd0;
            t = a;
         end else if (a >= ap_base && stop <= ap_base + ap_bytes) begin
            t = a - ap_base;
         end else if (stop < sys_limit) begin
            t = a + sys_base;
         end else begin
            return 64'd0;
         end
         if (t >= lim) return 64'd0;
         return t;
      endfunction

      function void note_request(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr,
                                 logic [LEN_W-1:0] len);
         reply_type   r;
         logic [63:0] a, l, t;
         status_type  st;
         bit          host_mem;
         int          free_slot, hit;
         a = 64'(addr);
         l = 64'(len);
         t = 64'd0;
         st = ST_OK;
         host_mem = 1'b0;
         free_slot = -1;
         hit = -1;
         if (act == ACT_UNKNOWN || l == 0) begin
            st = ST_RANGE;
         end else begin
            t = to_dma(a, l);
            if (t == 0) st = ST_RANGE;
         end
         if (st == ST_OK) begin
            host_mem = t > sys_base;
            if (act == ACT_REGISTER) begin
               for (int i = 0; i < MAX_REGIONS; i++) begin
                  if (slot_valid[i]) begin
                     if (t < slot_base[i] + slot_size[i] && slot_base[i] < t + l)
                        st = ST_OVERLAP;
                  end else if (free_slot < 0) begin
                     free_slot = i;
                  end
               end
               if (st == ST_OK && free_slot < 0) st = ST_FULL;
               if (st == ST_OK) begin
                  slot_valid[free_slot] = 1'b1;
                  slot_base[free_slot]  = t;
                  slot_size[free_slot]  = l;
                  slot_phys[free_slot]  = a;
               end
            end else begin
               for (int i = 0; i < MAX_REGIONS; i++)
                  if (hit < 0 && slot_valid[i] && slot_base[i] <= t &&
                      slot_base[i] + slot_size[i] >= t + l)
                     hit = i;
               if (hit < 0) st = ST_NOREG;
               else if (act == ACT_DEREGISTER) slot_valid[hit] = 1'b0;
            end
         end
         if (st != ST_OK) begin
            t = 64'd0;
            host_mem = 1'b0;
         end
         r.status   = st;
         r.bus_addr = t[DMA_SPACE_BITS-1:0];
         r.mem_type = host_mem;
         expected_replies.push_back(r);
         tally[int'(st)]++;
      endfunction

      function void check_reply(logic [STATUS_W-1:0] status,
                                logic [DMA_SPACE_BITS-1:0] bus_addr, logic mem_type);
         reply_type r;
         if (expected_replies.size() == 0) begin
            $display("%0t ns: response with nothing outstanding, status %0d addr %h",
                     $time, status, bus_addr);
            errors++;
            return;
         end
         r = expected_replies.pop_front();
         compared++;
         if (status !== r.status) begin
            $display("%0t ns: status expected %0d, got %0d", $time, r.status, status);
            errors++;
         end
         if (bus_addr !== r.bus_addr) begin
            $display("%0t ns: address expected %h, got %h", $time, r.bus_addr, bus_addr);
            errors++;
         end
         if (mem_type !== r.mem_type) begin
            $display("%0t ns: mem_type expected %0d, got %0d", $time, r.mem_type, mem_type);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [ACTION_W-1:0]       req_action = ACT_VERIFY;
   logic [ADDR_W-1:0]         req_phys_addr = '0;
   logic [LEN_W-1:0]          req_length = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic [DMA_SPACE_BITS-1:0] rsp_bus_addr;
   logic                      rsp_mem_type;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     paddr = '0;
   logic [CSR_DATA_W-1:0]     pwdata = '0;
   logic [CSR_DATA_W-1:0]     prdata;
   logic                      pready;

   region_table_shadow sb = new();
   bit   idle_on = 1'b1;
   logic hold_request = 1'b0;
   int   hold_left = 0;
   int   n_requests = 0;
   int   n_settings = 1;

   dma_region_check_table_unit uut (.*);

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("timeout, %0d responses still outstanding", sb.pending());
      $display("tb_top NOT OK");
      $finish;
   end

   // response side: check each transaction, random stalls, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_reply(rsp_status, rsp_bus_addr, rsp_mem_type);
         if (hold_request) begin
            hold_request <= 1'b0;
            hold_left = 150;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(idle_on && $urandom_range(99) < 12);
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_len();
      int          k;
      logic [63:0] l;
      k = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 0);
      l = 64'd1 << k;
      if (k < 40 && $urandom_range(9) == 0) l = 1 + rand64() % (l * 2);
      return l;
   endfunction

   // address range that translates under the current configuration
   function automatic void pick_window(output logic [63:0] lo, output logic [63:0] hi);
      if (sb.card_side) begin
         lo = 64'd0;
         hi = 64'd1 << DMA_SPACE_BITS;
      end else if (sb.ap_bytes != 0 && $urandom_range(1)) begin
         lo = sb.ap_base;
         hi = sb.ap_base + sb.ap_bytes;
      end else begin
         lo = 64'd0;
         hi = sb.sys_limit;
      end
   endfunction

   // clustered near either end of the window so regions collide often
   function automatic logic [63:0] pick_addr(logic [63:0] lo, logic [63:0] hi,
                                             logic [63:0] l);
      logic [63:0] span, slots, off;
      if (hi <= lo || hi - lo < l) return lo;
      span  = hi - lo - l;
      slots = span / l + 1;
      if (slots > 48 && $urandom_range(3) != 0) slots = 48;
      off = (rand64() % slots) * l;
      return $urandom_range(1) ? lo + off : hi - l - off;
   endfunction

   task automatic pick_request(output logic [ACTION_W-1:0] act,
                               output logic [ADDR_W-1:0] addr, output logic [LEN_W-1:0] len);
      int          roll, k;
      int          live[$];
      logic [63:0] lo, hi, l, off, sz;
      roll = $urandom_range(99);
      for (int i = 0; i < MAX_REGIONS; i++) if (sb.slot_valid[i]) live.push_back(i);
      if (roll < 35 || (roll < 70 && live.size() == 0)) begin
         act = ACT_REGISTER;
         l = pick_len();
         pick_window(lo, hi);
         addr = ADDR_W'(pick_addr(lo, hi, l));
         len = LEN_W'(l);
      end else if (roll < 70) begin
         // hit a stored region: part of it, all of it, or one byte past it
         k = live[$urandom_range(live.size() - 1)];
         sz = sb.slot_size[k];
         off = (sz > 1 && $urandom_range(3) != 0) ? rand64() % sz : 64'd0;
         l = ($urandom_range(4) == 0) ? sz - off : 1 + rand64() % (sz - off);
         if ($urandom_range(9) == 0) l = l + 1;
         act = ($urandom_range(9) < 3) ? ACT_DEREGISTER : ACT_VERIFY;
         addr = ADDR_W'(sb.slot_phys[k] + off);
         len = LEN_W'(l);
      end else if (roll < 85) begin
         act = $urandom_range(1) ? ACT_VERIFY : ACT_DEREGISTER;
         l = pick_len();
         pick_window(lo, hi);
         addr = ADDR_W'(pick_addr(lo, hi, l));
         len = LEN_W'(l);
      end else begin
         act = ACTION_W'($urandom_range(3));
         addr = ADDR_W'(rand64());
         case ($urandom_range(3))
            0: len = '0;
            1: len = LEN_W'(64'd1 << 40);
            default: len = LEN_W'(rand64() % ((64'd1 << 40) + 1));
         endcase
      end
   endtask

   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
      req_valid     <= 1'b1;
      req_action    <= act;
      req_phys_addr <= addr;
      req_length    <= len;
      do @(posedge clock); while (!req_ready);
      sb.note_request(act, addr, len);
      n_requests++;
      if (idle_on && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, {CSR_IDX_LSB{1'b0}}};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_csr(idx, value);
      @(posedge clock);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (MAX_REGIONS + 8) @(posedge clock);
   endtask

   task automatic drain_table();
      int guard, slot;
      guard = 0;
      while (guard < 2 * MAX_REGIONS) begin
         slot = -1;
         for (int i = 0; i < MAX_REGIONS; i++) if (slot < 0 && sb.slot_valid[i]) slot = i;
         if (slot < 0) break;
         send_request(ACT_DEREGISTER, ADDR_W'(sb.slot_phys[slot]),
                      LEN_W'(sb.slot_size[slot]));
         guard++;
      end
   endtask

   task automatic run_random(input int n_items, input int pause_at);
      logic [ACTION_W-1:0] act;
      logic [ADDR_W-1:0]   addr;
      logic [LEN_W-1:0]    len;
      for (int i = 0; i < n_items; i++) begin
         if (i == pause_at) wait_quiet();
         pick_request(act, addr, len);
         send_request(act, addr, len);
      end
      drain_table();
      wait_quiet();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default configuration: host side, sysmem offset and limit at 2^39
      send_request(ACT_REGISTER,   52'h1000, 41'h1000);
      send_request(ACT_REGISTER,   52'h1800, 41'h1000);
      send_request(ACT_VERIFY,     52'h1800, 41'h100);
      send_request(ACT_VERIFY,     52'h1800, 41'h1000);
      send_request(ACT_DEREGISTER, 52'h1000, 41'h1000);
      send_request(ACT_VERIFY,     52'h1000, 41'h1);
      send_request(ACT_UNKNOWN,    52'h1000, 41'h1000);
      send_request(ACT_REGISTER,   52'h0, 41'h0);
      send_request(ACT_VERIFY,     52'h0, 41'h0);
      send_request(ACT_DEREGISTER, 52'h0, 41'h0);
      send_request(ACT_VERIFY,     {ADDR_W{1'b1}}, LEN_W'(64'd1 << 40));
      send_request(ACT_REGISTER,   52'h0, 41'h3);  // odd size kept as given
      // fill the table, one more is full, an overlap wins over full
      for (int i = 0; i < MAX_REGIONS; i++)
         send_request(ACT_REGISTER, ADDR_W'(32'h10_0000 + i * 32'h100), 41'h100);
      send_request(ACT_REGISTER, 52'h1, 41'h1);
      drain_table();
      wait_quiet();
      run_random(110, 60);

      // card side, no idling at all on either channel
      csr_write(CSR_CARD_SIDE, 64'd1);
      n_settings++;
      idle_on = 1'b0;
      send_request(ACT_REGISTER, 52'h0, 41'h10);
      send_request(ACT_REGISTER, ADDR_W'((64'd1 << 40) - 64'h10), 41'h10);
      send_request(ACT_REGISTER, ADDR_W'((64'd1 << 40) - 64'h10), 41'h20);
      run_random(110, -1);
      idle_on = 1'b1;

      // host side with an aperture; response side holds off long enough to back up
      csr_write(CSR_CARD_SIDE, 64'd0);
      csr_write(CSR_APERT_BASE, 64'h100_0000_0000);
      csr_write(CSR_APERT_BYTES, 64'h1_0000_0000);
      csr_write(CSR_SYSMEM_BASE, 64'h10_0000_0000);
      csr_write(CSR_SYSMEM_LIMIT, 64'h1000_0000);
      n_settings++;
      hold_request <= 1'b1;
      run_random(120, 70);

      // extremes: translated value can reach past the 40-bit space
      csr_write(CSR_APERT_BASE, (64'd1 << ADDR_W) - 1);
      csr_write(CSR_APERT_BYTES, 64'd1 << 40);
      csr_write(CSR_SYSMEM_BASE, (64'd1 << 40) - 1);
      csr_write(CSR_SYSMEM_LIMIT, 64'd1 << 40);
      n_settings++;
      send_request(ACT_REGISTER,   52'h0, 41'h1);
      send_request(ACT_REGISTER,   52'h1, 41'h1);
      send_request(ACT_VERIFY,     {ADDR_W{1'b1}}, 41'h1);
      send_request(ACT_DEREGISTER, 52'h0, 41'h1);
      run_random(90, -1);

      // everything zero: nothing translates
      csr_write(CSR_APERT_BASE, 64'd0);
      csr_write(CSR_APERT_BYTES, 64'd0);
      csr_write(CSR_SYSMEM_BASE, 64'd0);
      csr_write(CSR_SYSMEM_LIMIT, 64'd0);
      n_settings++;
      run_random(30, -1);

      csr_write(CSR_CARD_SIDE, 64'($urandom_range(1)));
      csr_write(CSR_APERT_BASE, $urandom_range(1) ? rand64() & ((64'd1 << ADDR_W) - 1)
                                                  : rand64() % (64'd1 << 34));
      csr_write(CSR_APERT_BYTES, 64'd1 << $urandom_range(40, 12));
      csr_write(CSR_SYSMEM_BASE, rand64() % (64'd1 << 40));
      csr_write(CSR_SYSMEM_LIMIT, rand64() % ((64'd1 << 40) + 1));
      n_settings++;
      run_random(110, 50);

      $display("%0d requests under %0d register configurations, %0d responses compared",
               n_requests, n_settings, sb.compared);
      $display("ok %0d, out of range %0d, overlap %0d, not registered %0d, full %0d",
               sb.tally[0], sb.tally[1], sb.tally[2], sb.tally[3], sb.tally[4]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule
